FILE: hw/rtl/ns32kild_pkg.sv
`default_nettype none
package ns32kild_pkg;

	localparam int NumFormats = 17;

	// Result of the header match for one candidate header.
	typedef struct packed {
		logic       hit;
		logic [4:0] cls;
		logic [3:0] opc;
		logic [2:0] size;
		logic [4:0] mode_m;
		logic [4:0] mode_s;
	} ild_match_t;

	// Fixed bits and fields of one format table entry applied to a header.
	typedef struct packed {
		logic [23:0] mask;
		logic [23:0] val;
		logic [1:0]  nbytes;
		logic [3:0]  opc;
		logic        has_b;
		logic [1:0]  b;
		logic [4:0]  m;
		logic [4:0]  s;
	} fmt_entry_t;

	localparam logic [4:0] ClsRegList = 5'd1;
	localparam logic [4:0] ClsFmt9    = 5'd9;
	localparam logic [4:0] ClsExtIns  = 5'd10;
	localparam logic [4:0] ClsFmt14   = 5'd14;
	localparam logic [4:0] ModeScaled = 5'h1c;

	function automatic fmt_entry_t fmt_entry(input logic [4:0] e, input logic [23:0] h);
		fmt_entry_t r;
		r = '{mask: 24'h0, val: 24'h0, nbytes: 2'd0, opc: 4'd0, has_b: 1'b0, b: 2'd0,
			m: 5'd0, s: 5'd0};
		case (e)
			5'd0: begin
				r.mask = 24'h0f; r.val = 24'h0a; r.nbytes = 2'd1;
			end
			5'd1: begin
				r.mask = 24'h0f; r.val = 24'h02; r.nbytes = 2'd1; r.opc = h[7:4];
			end
			5'd2: begin
				r.mask = 24'h7c; r.val = 24'h3c; r.nbytes = 2'd2;
				r.has_b = 1'b1; r.b = h[1:0]; r.s = h[15:11];
			end
			5'd3: begin
				r.mask = 24'h3c; r.val = 24'h2c; r.nbytes = 2'd2; r.opc = {3'd0, h[6]};
				r.has_b = 1'b1; r.b = h[1:0]; r.s = h[15:11];
			end
			5'd4: begin
				r.mask = 24'h0c; r.val = 24'h0c; r.nbytes = 2'd2; r.opc = {1'b0, h[6:4]};
				r.has_b = 1'b1; r.b = h[1:0]; r.s = h[15:11];
			end
			5'd5: begin
				r.mask = 24'h7c; r.val = 24'h7c; r.nbytes = 2'd2; r.opc = h[10:7];
				r.has_b = 1'b1; r.b = h[1:0]; r.s = h[15:11];
			end
			5'd6: begin
				r.nbytes = 2'd2; r.opc = h[5:2];
				r.has_b = 1'b1; r.b = h[1:0]; r.m = h[15:11]; r.s = h[10:6];
			end
			5'd7: begin
				r.mask = 24'hf87cff; r.val = 24'h00080e; r.nbytes = 2'd3;
			end
			5'd8: begin
				r.mask = 24'hf840ff; r.val = 24'h00000e; r.nbytes = 2'd3; r.opc = h[13:10];
				r.has_b = 1'b1; r.b = h[9:8];
			end
			5'd9, 5'd10: begin
				r.mask = 24'hff; r.val = (e == ClsFmt9) ? 24'h4e : 24'hce; r.nbytes = 2'd3;
				r.opc = h[13:10]; r.has_b = 1'b1; r.b = h[9:8];
				r.m = h[23:19]; r.s = h[18:14];
			end
			5'd11: begin
				r.mask = 24'h43f; r.val = 24'h02e; r.nbytes = 2'd3; r.opc = {2'd0, h[7:6]};
				r.has_b = 1'b1; r.b = h[9:8]; r.m = h[23:19]; r.s = h[18:14];
			end
			5'd12: begin
				r.mask = 24'h4bf; r.val = 24'h42e; r.nbytes = 2'd3; r.opc = {3'd0, h[6]};
				r.has_b = 1'b1; r.b = h[9:8]; r.m = h[23:19]; r.s = h[18:14];
			end
			5'd13: begin
				r.mask = 24'h2cff; r.val = 24'h0cae; r.nbytes = 2'd3; r.opc = {3'd0, h[12]};
				r.has_b = 1'b1; r.b = h[9:8]; r.m = h[23:19]; r.s = h[18:14];
			end
			5'd14: begin
				r.mask = 24'hff; r.val = 24'h3e; r.nbytes = 2'd3; r.opc = {1'b0, h[13:11]};
				r.has_b = 1'b1; r.b = h[9:8]; r.m = h[23:19]; r.s = h[18:14];
			end
			5'd15: begin
				r.mask = 24'h2ff; r.val = 24'hbe; r.nbytes = 2'd3; r.opc = h[13:10];
				r.m = h[23:19]; r.s = h[18:14];
			end
			5'd16: begin
				r.mask = 24'h43ff; r.val = 24'h031e; r.nbytes = 2'd3; r.opc = h[13:10];
				r.s = h[23:19];
			end
			default: begin
				r.mask = 24'h0; r.val = 24'h1;
			end
		endcase
		return r;
	endfunction

	function automatic logic [15:0] slot_used(input logic [4:0] e);
		case (e)
			5'd0:  return 16'h0001;
			5'd1:  return 16'hffff;
			5'd2:  return 16'h0001;
			5'd3:  return 16'h0003;
			5'd4:  return 16'h0033;
			5'd5:  return 16'h5455;
			5'd6:  return 16'h7777;
			5'd7:  return 16'h0001;
			5'd8:  return 16'h000b;
			5'd9:  return 16'hfbef;
			5'd10: return 16'hfbff;
			5'd11: return 16'h000f;
			5'd12: return 16'h0003;
			5'd13: return 16'h0003;
			5'd14: return 16'h00ff;
			5'd15: return 16'h3137;
			5'd16: return 16'h000f;
			default: return 16'h0000;
		endcase
	endfunction

	function automatic logic [15:0] slot_tail(input logic [4:0] e);
		case (e)
			5'd0:  return 16'h0001;
			5'd1:  return 16'h011f;
			5'd4:  return 16'h0010;
			5'd10: return 16'h0003;
			5'd11: return 16'h0005;
			default: return 16'h0000;
		endcase
	endfunction

	// Format carries a first general operand field.
	function automatic logic has_m(input logic [4:0] e);
		return (e == 5'd6) || (e >= 5'd9 && e <= 5'd15);
	endfunction

	// Format carries a second general operand field.
	function automatic logic has_s(input logic [4:0] e);
		return (e >= 5'd2 && e <= 5'd6) || (e >= 5'd9 && e <= 5'd16);
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ns32kild_hdr_match.sv
`default_nettype none
module ns32kild_hdr_match (
	input  wire logic [23:0]             hdr,
	input  wire logic [1:0]              nbytes,
	output ns32kild_pkg::ild_match_t     match
);

	ns32kild_pkg::fmt_entry_t ent [ns32kild_pkg::NumFormats];
	logic [ns32kild_pkg::NumFormats-1:0] ok;
	logic [2:0] size [ns32kild_pkg::NumFormats];
	logic [15:0] used;

	always_comb begin
		for (int e = 0; e < ns32kild_pkg::NumFormats; e++) begin
			ent[e] = ns32kild_pkg::fmt_entry(5'(e), hdr);
			used = ns32kild_pkg::slot_used(5'(e));
			size[e] = ent[e].has_b ? ({1'b0, ent[e].b} + 3'd1) : 3'd4;
			ok[e] = (ent[e].nbytes == nbytes) && ((hdr & ent[e].mask) == ent[e].val)
				&& used[ent[e].opc];
			// size code 10 is legal only for one format 14 opcode
			if (ent[e].has_b && ent[e].b == 2'd2) begin
				if (5'(e) == ns32kild_pkg::ClsFmt14 && ent[e].opc == 4'd2) begin
					size[e] = 3'd4;
				end else begin
					ok[e] = 1'b0;
				end
			end
			if (5'(e) == ns32kild_pkg::ClsFmt9
				&& (ent[e].opc == 4'd0 || ent[e].opc == 4'd1 || ent[e].opc == 4'd5)) begin
				size[e] = 3'd1;
			end
		end
		match = '0;
		// lowest index wins
		for (int e = ns32kild_pkg::NumFormats - 1; e >= 0; e--) begin
			if (ok[e]) begin
				match.hit    = 1'b1;
				match.cls    = 5'(e);
				match.opc    = ent[e].opc;
				match.size   = size[e];
				match.mode_m = ent[e].m;
				match.mode_s = ent[e].s;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ns32k_instruction_length_decoder.sv
`default_nettype none
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready   | code_byte, begin_req
// result  | out       | out_valid / out_ready | length, recognized, format_class, opcode,
//         |           |                       | operand_size, has_first_operand, first_mode,
//         |           |                       | has_second_operand, second_mode
//
// One byte per cycle while results are taken: each transfer is decoded by the header
// match and the byte-count update, and its result (if any) lands in the output register.
// A new byte is taken whenever the output register is empty or is drained in the
// same cycle, so the block sustains one byte per clock with no gaps.
// Reset (arst_n low) empties the output register and leaves the decoder waiting for
// the first header byte.
module ns32k_instruction_length_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] code_byte,
	input  wire logic       begin_req,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [4:0] length,
	output      logic       recognized,
	output      logic [4:0] format_class,
	output      logic [3:0] opcode,
	output      logic [2:0] operand_size,
	output      logic       has_first_operand,
	output      logic [4:0] first_mode,
	output      logic       has_second_operand,
	output      logic [4:0] second_mode
);

	typedef enum logic [2:0] {
		PH_HEAD, PH_REGS, PH_IDX1, PH_IDX2, PH_OPR1, PH_OPR2, PH_DISP, PH_EXTRA
	} phase_t;

	// decoder state
	phase_t      phase_q, phase_d;
	logic [23:0] hdr_q, hdr_d;
	logic [4:0]  bt_q, bt_d;
	logic [4:0]  cls_q, cls_d;
	logic [3:0]  opc_q, opc_d;
	logic [2:0]  size_q, size_d;
	logic [9:0]  modes_q, modes_d;
	logic [9:0]  base_q, base_d;
	logic [2:0]  bp_q, bp_d;
	logic [1:0]  dp_q, dp_d;

	// output register
	logic        out_valid_q;
	logic [4:0]  length_q, cls_out_q, mode1_q, mode2_q;
	logic        rec_q, hm_q, hs_q;
	logic [3:0]  opc_out_q;
	logic [2:0]  size_out_q;

	logic        accept;
	phase_t      ph0;
	logic [23:0] hdr0, hdr_new;
	logic [4:0]  bt0, bt_inc;
	logic [2:0]  bp0;
	logic [1:0]  dp0;
	ns32kild_pkg::ild_match_t mt;
	logic        do_adv, emit, emit_ok;
	logic [2:0]  adv_start, sel;
	logic [7:1]  need;
	logic        found, hm, hs;
	logic [15:0] tail;
	logic [2:0]  disp_len;

	function automatic logic body_need(input logic [4:0] mode);
		return !(mode < 5'd8 || mode == 5'd23);
	endfunction

	function automatic logic [1:0] body_disps(input logic [4:0] mode);
		if (mode == 5'd20) return 2'd0;
		if (mode == 5'd16 || mode == 5'd17 || mode == 5'd18 || mode == 5'd22) return 2'd2;
		return 2'd1;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// restart request drops any partial instruction
	assign ph0  = begin_req ? PH_HEAD : phase_q;
	assign hdr0 = begin_req ? 24'd0 : hdr_q;
	assign bt0  = begin_req ? 5'd0 : bt_q;
	assign bp0  = begin_req ? 3'd0 : bp_q;
	assign dp0  = begin_req ? 2'd0 : dp_q;

	// byte count including this transfer, held at 31
	assign bt_inc = (ph0 == PH_HEAD || bt0 < 5'd31) ? bt0 + 5'd1 : bt0;

	always_comb begin
		case (bt0[1:0])
			2'd0:    hdr_new = hdr0 | {16'd0, code_byte};
			2'd1:    hdr_new = hdr0 | {8'd0, code_byte, 8'd0};
			2'd2:    hdr_new = hdr0 | {code_byte, 16'd0};
			default: hdr_new = hdr0;
		endcase
	end

	ns32kild_hdr_match u_match (
		.hdr    (hdr_new),
		.nbytes (bt0[1:0] + 2'd1),
		.match  (mt)
	);

	// displacement length code from its first byte
	always_comb begin
		if (!code_byte[7]) begin
			disp_len = 3'd0;
		end else if (code_byte[7:6] == 2'b10) begin
			disp_len = 3'd1;
		end else begin
			disp_len = 3'd3;
		end
	end

	always_comb begin
		phase_d   = ph0;
		hdr_d     = hdr0;
		bt_d      = bt0;
		cls_d     = cls_q;
		opc_d     = opc_q;
		size_d    = size_q;
		modes_d   = modes_q;
		base_d    = base_q;
		bp_d      = bp0;
		dp_d      = dp0;
		do_adv    = 1'b0;
		adv_start = 3'(PH_REGS);
		emit      = 1'b0;
		emit_ok   = 1'b0;

		if (ph0 == PH_HEAD) begin
			hdr_d = hdr_new;
			bt_d  = bt0 + 5'd1;
			if (mt.hit) begin
				cls_d   = mt.cls;
				opc_d   = mt.opc;
				size_d  = mt.size;
				modes_d = {mt.mode_s, mt.mode_m};
				base_d  = {mt.mode_s, mt.mode_m};
				do_adv  = 1'b1;
			end else if (bt0 >= 5'd2) begin
				// undecodable header: report and restart
				emit    = 1'b1;
				phase_d = PH_HEAD;
				hdr_d   = 24'd0;
				bt_d    = 5'd0;
				bp_d    = 3'd0;
				dp_d    = 2'd0;
			end
		end else begin
			if (bt0 < 5'd31) bt_d = bt0 + 5'd1;
			adv_start = 3'(ph0) + 3'd1;
			case (ph0)
				PH_REGS, PH_EXTRA: begin
					do_adv = 1'b1;
				end
				PH_IDX1: begin
					base_d[4:0] = code_byte[7:3];
					do_adv = 1'b1;
				end
				PH_IDX2: begin
					base_d[9:5] = code_byte[7:3];
					do_adv = 1'b1;
				end
				PH_OPR1, PH_OPR2, PH_DISP: begin
					if (bp0 != 3'd0) begin
						bp_d = bp0 - 3'd1;
					end else begin
						if (dp0 != 2'd0) dp_d = dp0 - 2'd1;
						bp_d = disp_len;
					end
					do_adv = (bp_d == 3'd0) && (dp_d == 2'd0);
				end
				default: begin
					do_adv = 1'b0;
				end
			endcase
		end

		// walk the remaining phases and stop at the first one that needs bytes
		hm   = ns32kild_pkg::has_m(cls_d);
		hs   = ns32kild_pkg::has_s(cls_d);
		tail = ns32kild_pkg::slot_tail(cls_d);
		need[1] = (cls_d == ns32kild_pkg::ClsRegList) && opc_d >= 4'd6 && opc_d <= 4'd9;
		need[2] = hm && modes_d[4:0] >= ns32kild_pkg::ModeScaled;
		need[3] = hs && modes_d[9:5] >= ns32kild_pkg::ModeScaled;
		need[4] = hm && body_need(base_d[4:0]);
		need[5] = hs && body_need(base_d[9:5]);
		need[6] = tail[opc_d];
		need[7] = (cls_d == ns32kild_pkg::ClsExtIns) && (opc_d == 4'd2 || opc_d == 4'd3);
		found = 1'b0;
		sel   = 3'd0;
		for (int k = 7; k >= 1; k--) begin
			if (need[k] && 3'(k) >= adv_start && adv_start != 3'd0) begin
				found = 1'b1;
				sel   = 3'(k);
			end
		end

		if (do_adv) begin
			if (found) begin
				phase_d = phase_t'(sel);
				case (phase_t'(sel))
					PH_OPR1: begin
						bp_d = (base_d[4:0] == 5'd20) ? size_d : 3'd0;
						dp_d = body_disps(base_d[4:0]);
					end
					PH_OPR2: begin
						bp_d = (base_d[9:5] == 5'd20) ? size_d : 3'd0;
						dp_d = body_disps(base_d[9:5]);
					end
					PH_DISP: begin
						bp_d = 3'd0;
						dp_d = 2'd1;
					end
					default: begin
						bp_d = bp_d;
					end
				endcase
			end else begin
				// instruction complete
				emit    = 1'b1;
				emit_ok = 1'b1;
				phase_d = PH_HEAD;
				hdr_d   = 24'd0;
				bt_d    = 5'd0;
				bp_d    = 3'd0;
				dp_d    = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			hdr_q   <= 24'd0;
			bt_q    <= 5'd0;
			cls_q   <= 5'd0;
			opc_q   <= 4'd0;
			size_q  <= 3'd4;
			modes_q <= 10'd0;
			base_q  <= 10'd0;
			bp_q    <= 3'd0;
			dp_q    <= 2'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			bt_q    <= bt_d;
			cls_q   <= cls_d;
			opc_q   <= opc_d;
			size_q  <= size_d;
			modes_q <= modes_d;
			base_q  <= base_d;
			bp_q    <= bp_d;
			dp_q    <= dp_d;
		end
	end

	// output register: load on an emitting transfer, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			length_q   <= emit_ok ? bt_inc : 5'd3;
			rec_q      <= emit_ok;
			cls_out_q  <= emit_ok ? cls_d : 5'd0;
			opc_out_q  <= emit_ok ? opc_d : 4'd0;
			size_out_q <= emit_ok ? size_d : 3'd4;
			hm_q       <= emit_ok && hm;
			mode1_q    <= (emit_ok && hm) ? modes_d[4:0] : 5'd0;
			hs_q       <= emit_ok && hs;
			mode2_q    <= (emit_ok && hs) ? modes_d[9:5] : 5'd0;
		end
	end

	assign out_valid          = out_valid_q;
	assign length             = length_q;
	assign recognized         = rec_q;
	assign format_class       = cls_out_q;
	assign opcode             = opc_out_q;
	assign operand_size       = size_out_q;
	assign has_first_operand  = hm_q;
	assign first_mode         = mode1_q;
	assign has_second_operand = hs_q;
	assign second_mode        = mode2_q;

`ifndef SYNTHESIS
	a_unrec_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !recognized |-> length == 5'd3)
		else $error("unrecognized result with wrong length");
	a_size_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && recognized |->
			(operand_size == 3'd1 || operand_size == 3'd2 || operand_size == 3'd4))
		else $error("illegal operand size");
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEAD |-> bt_q != 5'd0)
		else $error("operand phase with no bytes taken");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/ns32k_instruction_length_decoder_test.sv
`default_nettype none
module ns32k_instruction_length_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;
	localparam int RandomItems = 1400;

	// Decode phases of the length predictor.
	typedef enum int {
		PhHeader   = 0,
		PhRegList  = 1,
		PhIndex1   = 2,
		PhIndex2   = 3,
		PhBody1    = 4,
		PhBody2    = 5,
		PhTailDisp = 6,
		PhExtIns   = 7
	} decode_phase_e;

	typedef struct {
		logic [4:0] len;
		logic       rec;
		logic [4:0] cls;
		logic [3:0] opc;
		logic [2:0] osz;
		logic       has_m;
		logic [4:0] mode_m;
		logic       has_s;
		logic [4:0] mode_s;
	} insn_info_t;

	// One row of directed stimulus; typed rows carry their own expected result.
	typedef struct {
		logic [7:0] byte_val;
		logic       restart;
		bit         typed;
		bit         has_info;
		insn_info_t info;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] code_byte;
	logic       begin_req;
	logic       out_valid;
	logic       out_ready;
	logic [4:0] length;
	logic       recognized;
	logic [4:0] format_class;
	logic [3:0] opcode;
	logic [2:0] operand_size;
	logic       has_first_operand;
	logic [4:0] first_mode;
	logic       has_second_operand;
	logic [4:0] second_mode;

	ns32k_instruction_length_decoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.code_byte(code_byte), .begin_req(begin_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.length(length), .recognized(recognized), .format_class(format_class),
		.opcode(opcode), .operand_size(operand_size),
		.has_first_operand(has_first_operand), .first_mode(first_mode),
		.has_second_operand(has_second_operand), .second_mode(second_mode)
	);

	// Format table as bit patterns, most significant bit first.
	string fmt_pat [17] = '{
		"cccc1010", "xxxx0010",
		"22222cccc01111bb", "22222PPPPx1011bb", "22222ssssxxx11bb",
		"22222xxxx11111bb", "mmmmm22222xxxxbb",
		"00000CCGG00010--00001110", "00000SSSS0xxxxbb00001110",
		"mmmmm22222xxxxbb01001110", "mmmmm22222xxxxbb11001110",
		"mmmmm22222RRR0bbxx101110", "mmmmm22222RRR1bb0x101110",
		"mmmmm222220x11bb10101110", "mmmmm22222xxxfbb00111110",
		"mmmmm22222xxxx0f10111110", "22222MMMM0xxxx1100011110"
	};
	logic [15:0] opc_in_use [17] = '{
		16'h0001, 16'hffff, 16'h0001, 16'h0003, 16'h0033, 16'h5455, 16'h7777, 16'h0001,
		16'h000b, 16'hfbef, 16'hfbff, 16'h000f, 16'h0003, 16'h0003, 16'h00ff, 16'h3137,
		16'h000f
	};
	logic [15:0] opc_has_tail [17] = '{
		16'h0001, 16'h011f, 16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0003, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000
	};

	// Predictor state.
	logic [23:0]   hdr;
	int unsigned   taken;
	decode_phase_e phase;
	logic [4:0]    cur_cls;
	logic [3:0]    cur_opc;
	logic [2:0]    cur_size;
	logic [9:0]    raw_modes;
	logic [9:0]    count_modes;
	int unsigned   bytes_left;
	int unsigned   disps_left;

	insn_info_t pending_insns [$];
	bit         failed;
	bit         calm;
	int         cycles;
	int         n_bytes;
	int         n_insns;
	int         n_bad_hdr;

	// Extract the field named by letter c from value v; 0 if the pattern has none.
	function automatic bit pat_field(string p, byte c, logic [23:0] v, output logic [4:0] f);
		int n;
		int first;
		int cnt;
		n = p.len();
		first = n;
		cnt = 0;
		f = '0;
		for (int i = 0; i < n; i++) begin
			if (p[i] == c) begin
				if (first == n) first = i;
				cnt++;
			end
		end
		if (cnt == 0) return 0;
		f = 5'((v >> (n - first - cnt)) & ((24'd1 << cnt) - 1));
		return 1;
	endfunction

	function automatic bit pat_fits(string p, logic [23:0] v);
		int n;
		n = p.len();
		for (int j = 0; j < n; j++) begin
			if (p[j] == "0" && v[n - 1 - j]) return 0;
			if (p[j] == "1" && !v[n - 1 - j]) return 0;
		end
		return 1;
	endfunction

	function automatic bit match_header(int unsigned nbytes);
		logic [4:0] o;
		logic [4:0] b;
		int unsigned sz;
		for (int e = 0; e < 17; e++) begin
			if (fmt_pat[e].len() != 8 * nbytes || !pat_fits(fmt_pat[e], hdr)) continue;
			if (!pat_field(fmt_pat[e], "x", hdr, o)) o = 0;
			sz = pat_field(fmt_pat[e], "b", hdr, b) ? b + 1 : 4;
			if (sz == 3) begin
				if (e == 14 && o == 2) sz = 4;
				else continue;
			end
			if (!opc_in_use[e][o[3:0]]) continue;
			if (e == 9 && (o == 0 || o == 1 || o == 5)) sz = 1;
			cur_cls = 5'(e);
			cur_opc = o[3:0];
			cur_size = 3'(sz);
			return 1;
		end
		return 0;
	endfunction

	function automatic void drop_partial();
		hdr = '0;
		taken = 0;
		phase = PhHeader;
		bytes_left = 0;
		disps_left = 0;
	endfunction

	function automatic insn_info_t make_info(bit ok);
		insn_info_t r;
		logic [4:0] d;
		bit hm;
		bit hs;
		hm = ok && pat_field(fmt_pat[cur_cls], "m", 0, d);
		hs = ok && pat_field(fmt_pat[cur_cls], "2", 0, d);
		r.len = ok ? 5'(taken) : 5'd3;
		r.rec = ok;
		r.cls = ok ? cur_cls : 5'd0;
		r.opc = ok ? cur_opc : 4'd0;
		r.osz = ok ? cur_size : 3'd4;
		r.has_m = hm;
		r.mode_m = hm ? raw_modes[4:0] : 5'd0;
		r.has_s = hs;
		r.mode_s = hs ? raw_modes[9:5] : 5'd0;
		return r;
	endfunction

	// Load the byte counters for one operand body; 1 if it takes bytes.
	function automatic bit load_body(logic [4:0] mode);
		bytes_left = 0;
		disps_left = 0;
		if (mode < 8 || mode == 23) return 0;
		if (mode == 20) begin
			bytes_left = cur_size;
			return bytes_left != 0;
		end
		disps_left = (mode == 16 || mode == 17 || mode == 18 || mode == 22) ? 2 : 1;
		return 1;
	endfunction

	// Move on to the next phase that needs bytes, or finish the instruction.
	function automatic bit next_phase(int start, output insn_info_t r);
		logic [4:0] d;
		bit hm;
		bit hs;
		bit need;
		hm = pat_field(fmt_pat[cur_cls], "m", 0, d);
		hs = pat_field(fmt_pat[cur_cls], "2", 0, d);
		for (int ph = start; ph <= PhExtIns; ph++) begin
			case (ph)
				PhRegList: need = cur_cls == 1 && cur_opc >= 6 && cur_opc <= 9;
				PhIndex1: need = hm && raw_modes[4:0] >= 5'h1c;
				PhIndex2: need = hs && raw_modes[9:5] >= 5'h1c;
				PhBody1: need = hm && load_body(count_modes[4:0]);
				PhBody2: need = hs && load_body(count_modes[9:5]);
				PhTailDisp: begin
					need = opc_has_tail[cur_cls][cur_opc];
					bytes_left = 0;
					disps_left = 1;
				end
				default: need = cur_cls == 10 && (cur_opc == 2 || cur_opc == 3);
			endcase
			if (need) begin
				phase = decode_phase_e'(ph);
				return 0;
			end
		end
		r = make_info(1);
		drop_partial();
		return 1;
	endfunction

	function automatic bit decode_byte(logic [7:0] b, logic restart, output insn_info_t r);
		logic [4:0] m;
		logic [4:0] s;
		r = make_info(0);
		if (restart) drop_partial();
		if (phase == PhHeader) begin
			hdr = hdr | (24'(b) << (8 * (taken % 4)));
			taken++;
			if (match_header(taken)) begin
				if (!pat_field(fmt_pat[cur_cls], "m", hdr, m)) m = 0;
				if (!pat_field(fmt_pat[cur_cls], "2", hdr, s)) s = 0;
				raw_modes = {s, m};
				count_modes = raw_modes;
				return next_phase(PhRegList, r);
			end
			if (taken >= 3) begin
				r = make_info(0);
				drop_partial();
				return 1;
			end
			return 0;
		end
		if (taken < 31) taken++;
		case (phase)
			PhRegList: return next_phase(PhIndex1, r);
			PhIndex1: begin
				count_modes[4:0] = b[7:3];
				return next_phase(PhIndex2, r);
			end
			PhIndex2: begin
				count_modes[9:5] = b[7:3];
				return next_phase(PhBody1, r);
			end
			PhExtIns: return next_phase(PhExtIns + 1, r);
			default: begin
				if (bytes_left > 0) begin
					bytes_left--;
				end else begin
					if (disps_left > 0) disps_left--;
					if (!b[7]) bytes_left = 0;
					else if (b[7:6] == 2'b10) bytes_left = 1;
					else bytes_left = 3;
				end
				if (bytes_left == 0 && disps_left == 0) return next_phase(phase + 1, r);
				return 0;
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Count cycles and end the run as failed once the cycle limit is reached.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("ns32k_instruction_length_decoder test failed");
			$finish;
		end
	end

	// Result side: drop ready now and then, and compare every transfer with the
	// oldest instruction still owed.
	always @(posedge clk) begin
		insn_info_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 9);
			if (out_valid && out_ready) begin
				if (pending_insns.size() == 0) begin
					$error("result with no instruction owed, length %0d", length);
					failed = 1;
				end else begin
					want = pending_insns.pop_front();
					check_field("length", want.len, length);
					check_field("recognized", want.rec, recognized);
					check_field("format_class", want.cls, format_class);
					check_field("opcode", want.opc, opcode);
					check_field("operand_size", want.osz, operand_size);
					check_field("has_first_operand", want.has_m, has_first_operand);
					check_field("first_mode", want.mode_m, first_mode);
					check_field("has_second_operand", want.has_s, has_second_operand);
					check_field("second_mode", want.mode_s, second_mode);
				end
			end
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1;
		end
	endtask

	// Offer one byte and hold it until the transfer; idle first at random.
	task automatic send_byte(logic [7:0] b, logic restart);
		if (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		begin_req <= restart;
		do @(posedge clk); while (!in_ready);
		n_bytes++;
	endtask

	// Predict and send one byte; return 1 if it finishes an instruction.
	task automatic feed(logic [7:0] b, logic restart, output bit done);
		insn_info_t r;
		done = decode_byte(b, restart, r);
		if (done) begin
			pending_insns.push_back(r);
			n_insns++;
			if (!r.rec) n_bad_hdr++;
		end
		send_byte(b, restart);
	endtask

	task automatic wait_drained();
		while (pending_insns.size() != 0) @(posedge clk);
	endtask

	stim_row_t rows [$];

	function automatic void add_row(logic [7:0] b, logic restart);
		stim_row_t r;
		r.byte_val = b;
		r.restart = restart;
		r.typed = 0;
		r.has_info = 0;
		rows.push_back(r);
	endfunction

	function automatic void add_typed(logic [7:0] b, bit has_info, insn_info_t info);
		stim_row_t r;
		r.byte_val = b;
		r.restart = 1'b0;
		r.typed = 1;
		r.has_info = has_info;
		r.info = info;
		rows.push_back(r);
	endfunction

	initial begin
		insn_info_t none;
		insn_info_t bad_hdr;
		insn_info_t zero_pair;
		insn_info_t scratch;
		logic [23:0] v;
		int e;
		int n;
		int guard;
		bit done;

		failed = 0;
		calm = 0;
		cycles = 0;
		n_bytes = 0;
		n_insns = 0;
		n_bad_hdr = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		code_byte = '0;
		begin_req = 1'b0;
		out_ready = 1'b0;
		hdr = '0;
		drop_partial();
		cur_cls = '0;
		cur_opc = '0;
		cur_size = 3'd4;
		raw_modes = '0;
		count_modes = '0;

		none = '{default: '0};
		bad_hdr = '{len: 5'd3, rec: 1'b0, cls: 5'd0, opc: 4'd0, osz: 3'd4,
			has_m: 1'b0, mode_m: 5'd0, has_s: 1'b0, mode_s: 5'd0};
		zero_pair = '{len: 5'd2, rec: 1'b1, cls: 5'd6, opc: 4'd0, osz: 3'd1,
			has_m: 1'b1, mode_m: 5'd0, has_s: 1'b1, mode_s: 5'd0};

		// Two zero bytes: the catch-all two-operand format, byte size.
		add_typed(8'h00, 0, none);
		add_typed(8'h00, 1, zero_pair);
		// Header that no format accepts, and the all-ones extreme.
		add_typed(8'hfe, 0, none);
		add_typed(8'h00, 0, none);
		add_typed(8'h00, 1, bad_hdr);
		add_typed(8'hff, 0, none);
		add_typed(8'hff, 0, none);
		add_typed(8'hff, 1, bad_hdr);
		// Branch-style format with a trailing one-byte displacement.
		add_row(8'h0a, 1'b0);
		add_row(8'h7f, 1'b0);
		// Restart drops a partial header.
		add_row(8'hfe, 1'b0);
		add_row(8'h00, 1'b1);
		add_row(8'h00, 1'b0);
		// Register-list byte.
		add_row(8'h62, 1'b0);
		add_row(8'hff, 1'b0);
		// Both operands scaled: index bytes give modes 23 and 16.
		add_row(8'h03, 1'b0);
		add_row(8'hff, 1'b0);
		add_row(8'hb8, 1'b0);
		add_row(8'h80, 1'b0);
		add_row(8'h7f, 1'b0);
		add_row(8'h80, 1'b0);
		add_row(8'h00, 1'b0);
		// Extract/insert: header, the extra byte, then a byte that starts a new header.
		add_row(8'hce, 1'b0);
		add_row(8'h08, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h01, 1'b0);
		add_row(8'h05, 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				done = decode_byte(rows[i].byte_val, rows[i].restart, scratch);
				if (rows[i].has_info) begin
					pending_insns.push_back(rows[i].info);
					n_insns++;
					if (!rows[i].info.rec) n_bad_hdr++;
				end
				send_byte(rows[i].byte_val, rows[i].restart);
			end else begin
				feed(rows[i].byte_val, rows[i].restart, done);
			end
		end

		// Hold the sender until every owed result has drained.
		in_valid <= 1'b0;
		wait_drained();

		while (n_bytes < RandomItems + rows.size()) begin
			calm = (n_bytes > 600 && n_bytes < 800);
			if ($urandom_range(0, 9) == 0) begin
				// Noise: loose bytes, some with a restart.
				repeat ($urandom_range(1, 4))
					feed(8'($urandom), $urandom_range(0, 3) == 0, done);
			end else begin
				// Header with the fixed bits of a random format, then bytes until it ends.
				e = $urandom_range(0, 16);
				n = fmt_pat[e].len();
				v = 24'($urandom);
				for (int j = 0; j < n; j++) begin
					if (fmt_pat[e][j] == "0") v[n - 1 - j] = 1'b0;
					if (fmt_pat[e][j] == "1") v[n - 1 - j] = 1'b1;
				end
				done = 0;
				for (int k = 0; k < n / 8 && !done; k++)
					feed(v[8 * k +: 8], k == 0 && $urandom_range(0, 19) == 0, done);
				guard = 0;
				while (!done && guard < 40) begin
					feed(8'($urandom), 1'b0, done);
					guard++;
				end
			end
		end
		in_valid <= 1'b0;
		begin_req <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d byte transfers, %0d instructions, %0d bad headers",
			n_bytes, n_insns, n_bad_hdr);
		if (!failed) begin
			$display("ns32k_instruction_length_decoder test passed");
		end else begin
			$display("ns32k_instruction_length_decoder test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/ns32kild_pkg.sv
hw/rtl/ns32kild_hdr_match.sv
hw/rtl/ns32k_instruction_length_decoder.sv
tb/sv/ns32k_instruction_length_decoder_test.sv
